@@ hw/rtl/pfr_pkg.sv @@
// shared constants and types for the page frame replacement block
package pfr_pkg;

  // default build sizes
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 20;

  // configuration register indexes
  localparam logic CFG_POLICY   = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;
  localparam int   CFG_DATA_W   = 5;
  localparam logic [CFG_DATA_W-1:0] CAPACITY_RST = 5'd16;

  // replacement policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // access kind codes
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // time charges
  localparam logic [3:0] WB_COST    = 4'd10;
  localparam logic [3:0] FAULT_COST = 4'd5;
  localparam logic [3:0] COST_NONE  = 4'd0;

  // broadcast control from the top level to every frame cell
  typedef struct packed {
    logic en;         // a transaction is taken this cycle
    logic hit;        // page found in some cell
    logic lru;        // least recently used policy active
    logic evict;      // miss with the store full: drop the oldest entry
    logic write;      // access is a write
    logic hit_dirty;  // dirty mark of the matching cell
  } cell_ctl_t;

endpackage

@@ hw/rtl/pfr_cell.sv @@
// one page frame cell of the age-ordered chain
module pfr_cell #(
  parameter int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfr_pkg::cell_ctl_t   ctl,
  input  logic [PAGE_BITS-1:0] pg,
  input  logic                 prev_valid,
  input  logic                 next_valid,
  input  logic [PAGE_BITS-1:0] next_page,
  input  logic                 next_dirty,
  input  logic                 seen_in,
  input  logic                 hit_dirty_in,
  output logic                 valid_o,
  output logic [PAGE_BITS-1:0] page_o,
  output logic                 dirty_o,
  output logic                 seen_out,
  output logic                 hit_dirty_out
);

  logic                 valid_r, valid_nxt;
  logic                 dirty_r, dirty_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 match;
  logic                 tail_old;
  logic                 tail_new;
  logic                 moved;

  // compare and chain the match flags toward the newer end
  assign match         = valid_r && (page_r == pg);
  assign seen_out      = seen_in || match;
  assign hit_dirty_out = hit_dirty_in || (match && dirty_r);

  // newest occupied cell, and first free cell
  assign tail_old = valid_r && !next_valid;
  assign tail_new = !valid_r && prev_valid;

  // cells at or after the removed entry close the gap
  assign moved = valid_r && ((ctl.hit && ctl.lru && seen_out) || (!ctl.hit && ctl.evict));

  // next cell contents
  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    page_nxt  = page_r;
    if (ctl.en) begin
      if (ctl.hit && !ctl.lru) begin
        if (match && ctl.write) begin
          dirty_nxt = 1'b1;
        end
      end else if (moved) begin
        if (tail_old) begin
          page_nxt  = pg;
          dirty_nxt = ctl.write || (ctl.hit && ctl.hit_dirty);
        end else begin
          page_nxt  = next_page;
          dirty_nxt = next_dirty;
        end
      end else if (!ctl.hit && !ctl.evict && tail_new) begin
        valid_nxt = 1'b1;
        page_nxt  = pg;
        dirty_nxt = ctl.write;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  // page number storage
  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  assign valid_o = valid_r;
  assign page_o  = page_r;
  assign dirty_o = dirty_r;

endmodule

@@ hw/rtl/page_frame_replacement.sv @@
// top level of the page frame replacement block
// One access is taken per clock while the result register is empty or being
// taken, and its result appears in the next cycle. All frames sit in a chain of
// cells ordered oldest first; each cycle every cell compares its page with the
// access, and cells then shift one place toward the old end to close the gap
// left by a moved or evicted entry. The match chain through all FRAMES cells
// and the saturating 32-bit totals set the clock path. No clearing pass is
// needed after reset.
module page_frame_replacement #(
  parameter int FRAMES    = pfr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data,
  // access transactions
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_kind,
  input  logic [PAGE_BITS-1:0]           in_page,
  // result transactions
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit,
  output logic                           out_evicted_valid,
  output logic [PAGE_BITS-1:0]           out_evicted_page,
  output logic                           out_evicted_dirty,
  output logic [3:0]                     out_fault_cost,
  output logic [31:0]                    out_miss_total,
  output logic [31:0]                    out_writeback_total,
  output logic [31:0]                    out_fault_time_total
);

  localparam int CW   = $clog2(FRAMES + 1);
  localparam int CMPW = (CW > pfr_pkg::CFG_DATA_W) ? CW : pfr_pkg::CFG_DATA_W;
  localparam logic [CMPW-1:0] FRAMES_C = CMPW'(FRAMES);

  logic                           policy_r;
  logic [pfr_pkg::CFG_DATA_W-1:0] capacity_r;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [31:0]                    misses_r, misses_nxt;
  logic [31:0]                    wb_time_r, wb_time_nxt;
  logic [31:0]                    fault_time_r, fault_time_nxt;

  logic                           out_valid_r;
  logic                           hit_r;
  logic                           ev_valid_r;
  logic [PAGE_BITS-1:0]           ev_page_r;
  logic                           ev_dirty_r;
  logic [3:0]                     cost_r;

  logic                           take;
  logic [CMPW-1:0]                cap_raw;
  logic [CMPW-1:0]                cap_eff;
  logic                           full;
  logic                           hit;
  logic                           evict;
  logic                           ev_dirty;
  logic [3:0]                     wb;
  logic [3:0]                     cost;
  logic [32:0]                    miss_sum;
  logic [32:0]                    wb_sum;
  logic [32:0]                    ft_sum;
  pfr_pkg::cell_ctl_t             ctl;

  logic                           valid_w [FRAMES];
  logic [PAGE_BITS-1:0]           page_w  [FRAMES];
  logic                           dirty_w [FRAMES];
  logic                           seen_w  [FRAMES+1];
  logic                           hd_w    [FRAMES+1];

  // handshake: the result register frees as it is taken
  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= pfr_pkg::POLICY_FIFO;
      capacity_r <= pfr_pkg::CAPACITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pfr_pkg::CFG_POLICY:   policy_r   <= cfg_data[0];
        pfr_pkg::CFG_CAPACITY: capacity_r <= cfg_data;
        default:               policy_r   <= policy_r;
      endcase
    end
  end

  // effective capacity clamped to one through the built depth
  always_comb begin
    cap_raw = CMPW'(capacity_r);
    if (cap_raw == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_raw > FRAMES_C) begin
      cap_eff = FRAMES_C;
    end else begin
      cap_eff = cap_raw;
    end
  end

  assign full     = CMPW'(count_r) >= cap_eff;
  assign hit      = seen_w[FRAMES];
  assign evict    = !hit && full;
  assign ev_dirty = evict && dirty_w[0];

  // broadcast control
  always_comb begin
    ctl.en        = take;
    ctl.hit       = hit;
    ctl.lru       = (policy_r == pfr_pkg::POLICY_LRU);
    ctl.evict     = evict;
    ctl.write     = (in_kind == pfr_pkg::KIND_WRITE);
    ctl.hit_dirty = hd_w[FRAMES];
  end

  assign seen_w[0] = 1'b0;
  assign hd_w[0]   = 1'b0;

  // chain of frame cells, oldest at index zero
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    logic                 prev_v;
    logic                 next_v;
    logic [PAGE_BITS-1:0] next_p;
    logic                 next_d;
    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valid_w[i-1];
    end
    if (i == FRAMES - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_p = '0;
      assign next_d = 1'b0;
    end else begin : g_inner
      assign next_v = valid_w[i+1];
      assign next_p = page_w[i+1];
      assign next_d = dirty_w[i+1];
    end
    pfr_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .pg           (in_page),
      .prev_valid   (prev_v),
      .next_valid   (next_v),
      .next_page    (next_p),
      .next_dirty   (next_d),
      .seen_in      (seen_w[i]),
      .hit_dirty_in (hd_w[i]),
      .valid_o      (valid_w[i]),
      .page_o       (page_w[i]),
      .dirty_o      (dirty_w[i]),
      .seen_out     (seen_w[i+1]),
      .hit_dirty_out(hd_w[i+1])
    );
  end

  // fault charges and saturating totals
  assign wb       = ev_dirty ? pfr_pkg::WB_COST : pfr_pkg::COST_NONE;
  assign cost     = hit ? pfr_pkg::COST_NONE : 4'(pfr_pkg::FAULT_COST + wb);
  assign miss_sum = {1'b0, misses_r} + 33'd1;
  assign wb_sum   = {1'b0, wb_time_r} + 33'(wb);
  assign ft_sum   = {1'b0, fault_time_r} + 33'(cost);

  always_comb begin
    count_nxt      = count_r;
    misses_nxt     = misses_r;
    wb_time_nxt    = wb_time_r;
    fault_time_nxt = fault_time_r;
    if (take && !hit) begin
      if (!evict) begin
        count_nxt = count_r + CW'(1);
      end
      misses_nxt     = miss_sum[32] ? '1 : miss_sum[31:0];
      wb_time_nxt    = wb_sum[32]   ? '1 : wb_sum[31:0];
      fault_time_nxt = ft_sum[32]   ? '1 : ft_sum[31:0];
    end
  end

  // occupancy and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      misses_r     <= '0;
      wb_time_r    <= '0;
      fault_time_r <= '0;
    end else begin
      count_r      <= count_nxt;
      misses_r     <= misses_nxt;
      wb_time_r    <= wb_time_nxt;
      fault_time_r <= fault_time_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      hit_r      <= hit;
      ev_valid_r <= evict;
      ev_page_r  <= evict ? page_w[0] : '0;
      ev_dirty_r <= ev_dirty;
      cost_r     <= cost;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = hit_r;
  assign out_evicted_valid    = ev_valid_r;
  assign out_evicted_page     = ev_page_r;
  assign out_evicted_dirty    = ev_dirty_r;
  assign out_fault_cost       = cost_r;
  assign out_miss_total       = misses_r;
  assign out_writeback_total  = wb_time_r;
  assign out_fault_time_total = fault_time_r;

endmodule

@@ hw/rtl/pfr_checker.sv @@
// port-level checks for the page frame replacement block
module pfr_checker #(
  parameter int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_hit,
  input logic                 out_evicted_valid,
  input logic [PAGE_BITS-1:0] out_evicted_page,
  input logic                 out_evicted_dirty,
  input logic [3:0]           out_fault_cost,
  input logic [31:0]          out_miss_total
);

  // a hit never evicts and costs nothing
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid && out_fault_cost == pfr_pkg::COST_NONE)
    else $error("hit transaction reports an eviction or a charge");

  // a fault costs the base charge plus write-back of a dirty victim
  a_miss_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |->
      out_fault_cost == (out_evicted_dirty ? 4'(pfr_pkg::FAULT_COST + pfr_pkg::WB_COST)
                                            : pfr_pkg::FAULT_COST))
    else $error("fault charge does not match the eviction");

  // no eviction means empty victim fields
  a_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0 && !out_evicted_dirty)
    else $error("victim fields set without an eviction");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_miss_total) && $stable(out_hit))
    else $error("stalled result changed");

endmodule

bind page_frame_replacement pfr_checker #(.PAGE_BITS(PAGE_BITS)) u_pfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_hit          (out_hit),
  .out_evicted_valid(out_evicted_valid),
  .out_evicted_page (out_evicted_page),
  .out_evicted_dirty(out_evicted_dirty),
  .out_fault_cost   (out_fault_cost),
  .out_miss_total   (out_miss_total)
);

@@ tb/page_frame_replacement_tb.sv @@
// self-checking testbench for the page frame replacement block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES = pfr_pkg::FRAMES_DEF;
  localparam int PAGE_W = pfr_pkg::PAGE_BITS_DEF;
  localparam int unsigned LIMIT_CYCLES = 200000;

  // one access and the outcome it should produce
  typedef struct packed {
    logic              kind;
    logic [PAGE_W-1:0] page;
  } access_t;

  typedef struct packed {
    logic              hit;
    logic              ev_valid;
    logic [PAGE_W-1:0] ev_page;
    logic              ev_dirty;
    logic [3:0]        cost;
    logic [31:0]       misses;
    logic [31:0]       wb_total;
    logic [31:0]       fault_total;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = pfr_pkg::CFG_POLICY;
  logic [pfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = pfr_pkg::KIND_READ;
  logic [PAGE_W-1:0] in_page = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic out_evicted_valid;
  logic [PAGE_W-1:0] out_evicted_page;
  logic out_evicted_dirty;
  logic [3:0] out_fault_cost;
  logic [31:0] out_miss_total;
  logic [31:0] out_writeback_total;
  logic [31:0] out_fault_time_total;

  page_frame_replacement DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_page              (in_page),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_hit              (out_hit),
    .out_evicted_valid    (out_evicted_valid),
    .out_evicted_page     (out_evicted_page),
    .out_evicted_dirty    (out_evicted_dirty),
    .out_fault_cost       (out_fault_cost),
    .out_miss_total       (out_miss_total),
    .out_writeback_total  (out_writeback_total),
    .out_fault_time_total (out_fault_time_total)
  );

  always #5 clk = ~clk;

  // predicted frame store, registers and totals
  logic [PAGE_W-1:0] resident_page [FRAMES];
  logic              resident_dirty [FRAMES];
  int                resident_n = 0;
  logic              policy_reg = pfr_pkg::POLICY_FIFO;
  logic [4:0]        frame_limit = pfr_pkg::CAPACITY_RST;
  logic [31:0]       miss_count = '0;
  logic [31:0]       wb_time = '0;
  logic [31:0]       fault_time = '0;

  access_t           access_q [$];
  outcome_t          outcome_q [$];
  logic [PAGE_W-1:0] page_pool [$];
  access_t           next_access;
  outcome_t          predicted;
  outcome_t          oldest;
  logic              in_taken = 1'b0;
  int unsigned       cycle_count = 0;
  int                error_count = 0;
  int                checked_count = 0;
  int                hit_count = 0;
  int                evict_count = 0;
  int                dirty_evict_count = 0;
  int                setting_count = 1;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // remove one entry and close the gap toward the old end
  task automatic drop_frame(input int idx);
    for (int i = idx; i + 1 < resident_n; i++) begin
      resident_page[i] = resident_page[i + 1];
      resident_dirty[i] = resident_dirty[i + 1];
    end
    resident_n--;
    resident_dirty[resident_n] = 1'b0;
  endtask

  // lookup, replacement and time charges for one access
  task automatic replace_and_charge(input logic kind, input logic [PAGE_W-1:0] page,
                                    output outcome_t o);
    int slot;
    int lim;
    logic d;
    logic [31:0] wb;
    o = '0;
    slot = -1;
    wb = '0;
    lim = (frame_limit == 0) ? 1 : ((frame_limit > FRAMES) ? FRAMES : int'(frame_limit));
    for (int i = 0; i < resident_n; i++) begin
      if (slot < 0 && resident_page[i] == page) slot = i;
    end
    if (slot >= 0) begin
      o.hit = 1'b1;
      o.cost = pfr_pkg::COST_NONE;
      d = resident_dirty[slot] | (kind == pfr_pkg::KIND_WRITE);
      if (policy_reg == pfr_pkg::POLICY_LRU) begin
        drop_frame(slot);
        resident_page[resident_n] = page;
        resident_dirty[resident_n] = d;
        resident_n++;
      end else begin
        resident_dirty[slot] = d;
      end
    end else begin
      // a miss evicts at most the single oldest entry
      if (resident_n >= lim && resident_n > 0) begin
        o.ev_valid = 1'b1;
        o.ev_page = resident_page[0];
        o.ev_dirty = resident_dirty[0];
        if (o.ev_dirty) wb = {28'd0, pfr_pkg::WB_COST};
        drop_frame(0);
      end
      if (resident_n < FRAMES) begin
        resident_page[resident_n] = page;
        resident_dirty[resident_n] = (kind == pfr_pkg::KIND_WRITE);
        resident_n++;
      end
      o.cost = pfr_pkg::FAULT_COST + wb[3:0];
      miss_count = sat_add32(miss_count, 32'd1);
      wb_time = sat_add32(wb_time, wb);
      fault_time = sat_add32(fault_time, {28'd0, o.cost});
    end
    o.misses = miss_count;
    o.wb_total = wb_time;
    o.fault_total = fault_time;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // random gaps, switched off in one long window that recurs periodically
  function automatic logic idle_now();
    if ((cycle_count % 2000) >= 1400) return 1'b0;
    return ($urandom_range(99) < 12);
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("page_frame_replacement: mismatch");
      $finish;
    end
  end

  // access driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_taken = 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (access_q.size() != 0 && !idle_now()) begin
        next_access = access_q.pop_front();
        in_valid <= 1'b1;
        in_kind <= next_access.kind;
        in_page <= next_access.page;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n ? idle_now() : 1'b0;
  end

  // register writes, accepted accesses and result checks
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == pfr_pkg::CFG_POLICY) policy_reg = cfg_data[0];
        else frame_limit = cfg_data;
      end
      if (in_valid && !in_stall) begin
        replace_and_charge(in_kind, in_page, predicted);
        outcome_q.push_back(predicted);
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result transaction with nothing outstanding");
          error_count++;
        end else begin
          oldest = outcome_q.pop_front();
          checked_count++;
          if (oldest.hit) hit_count++;
          if (oldest.ev_valid) evict_count++;
          if (oldest.ev_dirty) dirty_evict_count++;
          check_field("hit", oldest.hit, out_hit);
          check_field("evicted_valid", oldest.ev_valid, out_evicted_valid);
          check_field("evicted_page", oldest.ev_page, out_evicted_page);
          check_field("evicted_dirty", oldest.ev_dirty, out_evicted_dirty);
          check_field("fault_cost", oldest.cost, out_fault_cost);
          check_field("miss_total", oldest.misses, out_miss_total);
          check_field("writeback_total", oldest.wb_total, out_writeback_total);
          check_field("fault_time_total", oldest.fault_total, out_fault_time_total);
        end
      end
    end
  end

  task automatic push_access(input logic kind, input logic [PAGE_W-1:0] page);
    access_t a;
    a.kind = kind;
    a.page = page;
    access_q.push_back(a);
  endtask

  // wait until no transaction is queued, in flight or outstanding
  task automatic wait_drained();
    do @(posedge clk);
    while (access_q.size() != 0 || in_valid || outcome_q.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [pfr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_mode(input logic pol, input logic [pfr_pkg::CFG_DATA_W-1:0] cap);
    wait_drained();
    write_reg(pfr_pkg::CFG_POLICY, {4'd0, pol});
    write_reg(pfr_pkg::CFG_CAPACITY, cap);
    setting_count++;
  endtask

  // random accesses, mostly drawn from a small set of pages so hits occur
  task automatic run_phase(input logic pol, input logic [pfr_pkg::CFG_DATA_W-1:0] cap,
                           input int n, input int pool_n);
    int r;
    logic [PAGE_W-1:0] p;
    set_mode(pol, cap);
    page_pool.delete();
    for (int i = 0; i < pool_n; i++) page_pool.push_back(PAGE_W'($urandom));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 80) p = page_pool[$urandom_range(pool_n - 1)];
      else if (r < 85) p = $urandom_range(1) ? '1 : '0;
      else p = PAGE_W'($urandom);
      push_access($urandom_range(1) ? pfr_pkg::KIND_WRITE : pfr_pkg::KIND_READ, p);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: page extremes, write misses followed by read hits
    push_access(pfr_pkg::KIND_WRITE, '0);
    push_access(pfr_pkg::KIND_READ, '0);
    push_access(pfr_pkg::KIND_WRITE, '1);
    push_access(pfr_pkg::KIND_READ, '1);
    push_access(pfr_pkg::KIND_READ, 20'h55555);
    push_access(pfr_pkg::KIND_WRITE, 20'hAAAAA);

    // zero capacity acts as one frame, below the resident count; lru single frame
    set_mode(pfr_pkg::POLICY_LRU, 5'd0);
    push_access(pfr_pkg::KIND_READ, 20'h12345);
    push_access(pfr_pkg::KIND_READ, 20'h12345);
    push_access(pfr_pkg::KIND_WRITE, 20'h12345);
    push_access(pfr_pkg::KIND_READ, 20'h00001);
    push_access(pfr_pkg::KIND_READ, 20'h00002);

    // two frames fifo: a hit keeps order, dirty victim
    set_mode(pfr_pkg::POLICY_FIFO, 5'd2);
    push_access(pfr_pkg::KIND_WRITE, 20'h0000A);
    push_access(pfr_pkg::KIND_READ, 20'h0000B);
    push_access(pfr_pkg::KIND_READ, 20'h0000A);
    push_access(pfr_pkg::KIND_READ, 20'h0000C);

    // two frames lru: a hit moves the page to the recent end
    set_mode(pfr_pkg::POLICY_LRU, 5'd2);
    push_access(pfr_pkg::KIND_READ, 20'h0000A);
    push_access(pfr_pkg::KIND_READ, 20'h0000B);
    push_access(pfr_pkg::KIND_READ, 20'h0000A);
    push_access(pfr_pkg::KIND_READ, 20'h0000C);

    // random phases over policies and capacities, extremes included
    run_phase(pfr_pkg::POLICY_FIFO, 5'd16, 250, 20);
    run_phase(pfr_pkg::POLICY_LRU, 5'd16, 250, 20);
    run_phase(pfr_pkg::POLICY_LRU, 5'd4, 200, 7);
    run_phase(pfr_pkg::POLICY_FIFO, 5'd1, 150, 3);
    run_phase(pfr_pkg::POLICY_LRU, 5'd1, 150, 3);
    run_phase(pfr_pkg::POLICY_FIFO, 5'd31, 200, 20);
    run_phase(pfr_pkg::POLICY_LRU, 5'd17, 200, 20);
    run_phase(pfr_pkg::POLICY_FIFO, 5'd0, 100, 3);
    run_phase(pfr_pkg::POLICY_LRU, 5'd8, 200, 11);
    run_phase(pfr_pkg::POLICY_FIFO, 5'd5, 220, 8);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("checked %0d access results across %0d register settings", checked_count,
             setting_count);
    $display("%0d hits, %0d evictions, %0d of them dirty", hit_count, evict_count,
             dirty_evict_count);
    if (error_count == 0 && outcome_q.size() == 0)
      $display("page_frame_replacement: match");
    else
      $display("page_frame_replacement: mismatch");
    $finish;
  end

endmodule
